@@ rtl/cpm_pkg.sv @@
// Shared constants and types of the character-class pattern matcher.
package cpm_pkg;

   localparam int CHAR_W     = 7;
   localparam int CHAR_COUNT = 128;
   localparam int ACTION_W   = 2;
   localparam int ELEM_W     = 4;
   localparam int KIND_W     = 3;
   localparam int START_W    = 16;
   localparam int LEN_W      = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Action codes of an input word.
   localparam logic [ACTION_W-1:0] ACT_DEFINE     = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ADD_MEMBER = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SOURCE     = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_NOP        = 2'd3;

   // Element kinds.
   localparam logic [KIND_W-1:0] KIND_LITERAL = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ANY     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_LOWER   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_UPPER   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SET     = 3'd4;
   localparam logic [KIND_W-1:0] KIND_NEG_SET = 3'd5;

   // Letter range bounds.
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;
   localparam logic [CHAR_W-1:0] CH_LOWER_Z = 7'h7A;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;
   localparam logic [CHAR_W-1:0] CH_UPPER_Z = 7'h5A;

   // Register map: the register index is address bit 2.
   localparam int          CSR_INDEX_BIT      = 2;
   localparam logic [0:0]  REG_PATTERN_LENGTH = 1'b0;
   localparam logic [LEN_W-1:0] LEN_RESET     = 5'd1;

   // One access to the accept table.
   typedef struct packed {
      logic              en;
      logic [CHAR_W-1:0] addr;
   } tbl_access_type;

endpackage

@@ rtl/cpm_req_if.sv @@
// Input word channel of the pattern matcher.
interface cpm_req_if;
   logic                          valid;
   logic                          ready;
   logic [cpm_pkg::ACTION_W-1:0]  action;
   logic [cpm_pkg::ELEM_W-1:0]    element_index;
   logic [cpm_pkg::KIND_W-1:0]    element_kind;
   logic [cpm_pkg::CHAR_W-1:0]    character;
   logic                          last_char;

   modport source (output valid, action, element_index, element_kind, character, last_char,
                   input ready);
   modport sink   (input valid, action, element_index, element_kind, character, last_char,
                   output ready);
endinterface

@@ rtl/cpm_rsp_if.sv @@
// Result word channel of the pattern matcher.
interface cpm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         match_found;
   logic [cpm_pkg::START_W-1:0]  match_start;
   logic                         search_done;

   modport source (output valid, match_found, match_start, search_done, input ready);
   modport sink   (input valid, match_found, match_start, search_done, output ready);
endinterface

@@ rtl/cpm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module cpm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/cpm_table.sv @@
// Per-character accept table: RAM plus one valid bit per entry, unwritten entries read as zero.
module cpm_table #(
   parameter int WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cpm_pkg::tbl_access_type rd_req,
   input  cpm_pkg::tbl_access_type wr_req,
   input  logic [WIDTH-1:0]        wr_data,
   output logic [WIDTH-1:0]        rd_data
);

   logic [cpm_pkg::CHAR_COUNT-1:0] valid_ff;
   logic                           rd_valid_ff;
   logic [WIDTH-1:0]               ram_data;

   cpm_ram #(
      .WIDTH (WIDTH),
      .DEPTH (cpm_pkg::CHAR_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_req.en),
      .wr_addr (wr_req.addr),
      .wr_data (wr_data),
      .rd_en   (rd_req.en),
      .rd_addr (rd_req.addr),
      .rd_data (ram_data)
   );

   // The sequencer never reads and writes the same entry in one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_req.en) begin
            valid_ff[wr_req.addr] <= 1'b1;
         end
         if (rd_req.en) begin
            rd_valid_ff <= valid_ff[rd_req.addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? ram_data : '0;

endmodule

@@ rtl/cpm_csr.sv @@
// APB-style register block holding pattern_length and its decoded length mask.
module cpm_csr #(
   parameter int MAX_PATTERN = 16,
   localparam int PW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [cpm_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [cpm_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [cpm_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output logic [PW-1:0]                    top_idx,
   output logic [MAX_PATTERN-1:0]           len_mask
);

   logic [cpm_pkg::LEN_W-1:0] length_ff;
   logic [cpm_pkg::LEN_W-1:0] length_in;
   logic                      reg_hit;
   int                        last_elem;

   assign reg_hit = (paddr[cpm_pkg::CSR_INDEX_BIT] == cpm_pkg::REG_PATTERN_LENGTH);
   assign pready  = 1'b1;
   assign prdata  = reg_hit ? {{(cpm_pkg::CSR_DATA_W - cpm_pkg::LEN_W){1'b0}}, length_ff}
                            : '0;

   always_comb begin
      length_in = length_ff;
      if (psel && penable && pwrite && reg_hit) begin
         length_in = pwdata[cpm_pkg::LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= cpm_pkg::LEN_RESET;
      end else begin
         length_ff <= length_in;
      end
   end

   // A length of zero acts as one; lengths above the pattern capacity are clipped.
   always_comb begin
      if (length_ff == '0) begin
         last_elem = 0;
      end else if (int'(length_ff) > MAX_PATTERN) begin
         last_elem = MAX_PATTERN - 1;
      end else begin
         last_elem = int'(length_ff) - 1;
      end
      for (int i = 0; i < MAX_PATTERN; i++) begin
         len_mask[i] = (i <= last_elem);
      end
   end

   assign top_idx = PW'(last_elem);

endmodule

@@ rtl/character_class_pattern_matcher.sv @@
// Top level of the character-class pattern matcher (shift-and over a per-character table).
// Flow: a source word passes ST_MATCH and a set-member word ST_SET (table read, then update)
// before ST_RESP loads the result register; a no-op or an ignored define or set-member word goes
// straight to ST_RESP, and a define first rewrites all 128 table entries, one per cycle, in ST_SWEEP.
// One word in flight; the next is taken the cycle after the result register loads, later while an
// earlier result still waits. Synchronous reset clears control state and table valid bits: no clear pass.
module character_class_pattern_matcher #(
   parameter int MAX_PATTERN = 16,
   parameter int MAX_SOURCE  = 65536
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [cpm_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [cpm_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [cpm_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   cpm_req_if.sink                         req_ch,
   cpm_rsp_if.source                       rsp_ch
);

   localparam int PW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int PSW = $clog2(MAX_SOURCE);
   // The start difference is kept wide enough to see both a borrow and an overflow of 16 bits.
   localparam int DW  = ((PSW > cpm_pkg::START_W) ? PSW : cpm_pkg::START_W) + 2;
   localparam logic [PSW-1:0] POS_MAX = PSW'(MAX_SOURCE - 1);
   localparam logic [cpm_pkg::CHAR_W-1:0] LAST_CHAR_CODE =
      cpm_pkg::CHAR_W'(cpm_pkg::CHAR_COUNT - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_SET,
      ST_MATCH,
      ST_RESP
   } state_type;

   // Whether an element of the given kind accepts character c when it is defined.
   function automatic logic element_accepts(input logic [cpm_pkg::KIND_W-1:0] kind,
                                            input logic [cpm_pkg::CHAR_W-1:0] c,
                                            input logic [cpm_pkg::CHAR_W-1:0] lit);
      logic on;
      unique case (kind)
         cpm_pkg::KIND_LITERAL: on = (c == lit);
         cpm_pkg::KIND_ANY:     on = 1'b1;
         cpm_pkg::KIND_LOWER:   on = (c >= cpm_pkg::CH_LOWER_A) && (c <= cpm_pkg::CH_LOWER_Z);
         cpm_pkg::KIND_UPPER:   on = (c >= cpm_pkg::CH_UPPER_A) && (c <= cpm_pkg::CH_UPPER_Z);
         cpm_pkg::KIND_SET:     on = 1'b0;
         default:               on = 1'b1;   // a negated set starts out accepting everything
      endcase
      return on;
   endfunction

   // Control state.
   state_type                    state_ff, state_in;
   logic [cpm_pkg::CHAR_W-1:0]   sweep_ff, sweep_in;
   logic [MAX_PATTERN-1:0]       pm_ff, pm_in;
   logic [PSW-1:0]               pos_ff, pos_in;
   logic                         found_ff, found_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // The word being worked on, captured at acceptance.
   logic [cpm_pkg::ELEM_W-1:0]   elem_ff, elem_in;
   logic [cpm_pkg::KIND_W-1:0]   kind_ff, kind_in;
   logic [cpm_pkg::CHAR_W-1:0]   char_ff, char_in;
   logic                         last_ff, last_in;

   // Pending result and the output register.
   logic                         res_found_ff, res_found_in;
   logic [cpm_pkg::START_W-1:0]  res_start_ff, res_start_in;
   logic                         res_done_ff, res_done_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic [cpm_pkg::START_W-1:0]  rsp_start_ff, rsp_start_in;
   logic                         rsp_done_ff, rsp_done_in;

   // Table access and length decode.
   cpm_pkg::tbl_access_type      rd_req, wr_req;
   logic [MAX_PATTERN-1:0]       wr_data, rd_data;
   logic [PW-1:0]                top_idx;
   logic [MAX_PATTERN-1:0]       len_mask;

   logic                         accept;
   logic                         req_elem_ok;
   logic [MAX_PATTERN-1:0]       elem_bit;
   logic [MAX_PATTERN-1:0]       next_pm;
   logic [DW-1:0]                start_diff;
   logic [cpm_pkg::START_W-1:0]  start_sat;

   cpm_csr #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (csr_psel),
      .penable  (csr_penable),
      .pwrite   (csr_pwrite),
      .paddr    (csr_paddr),
      .pwdata   (csr_pwdata),
      .prdata   (csr_prdata),
      .pready   (csr_pready),
      .top_idx  (top_idx),
      .len_mask (len_mask)
   );

   cpm_table #(
      .WIDTH (MAX_PATTERN)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_req  (rd_req),
      .wr_req  (wr_req),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   // One word is in flight at a time; the block takes a new word only when idle.
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && (state_ff == ST_IDLE);
   assign req_elem_ok  = (int'(req_ch.element_index) < MAX_PATTERN);
   assign elem_bit     = MAX_PATTERN'(1) << elem_ff;

   // Shift-and step: every live partial match grows by one, a new one starts at element 0,
   // and only those the current character satisfies survive.
   assign next_pm    = ((pm_ff << 1) | MAX_PATTERN'(1)) & rd_data & len_mask;
   // Start of the match is the current index minus (length - 1); a borrow or anything
   // beyond 16 bits saturates at the largest start value.
   assign start_diff = DW'(pos_ff) - DW'(top_idx);
   assign start_sat  = (|start_diff[DW-1:cpm_pkg::START_W]) ? '1
                                                              : start_diff[cpm_pkg::START_W-1:0];

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.match_found = rsp_found_ff;
   assign rsp_ch.match_start = rsp_start_ff;
   assign rsp_ch.search_done = rsp_done_ff;

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      pm_in        = pm_ff;
      pos_in       = pos_ff;
      found_in     = found_ff;
      elem_in      = elem_ff;
      kind_in      = kind_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      res_found_in = res_found_ff;
      res_start_in = res_start_ff;
      res_done_in  = res_done_ff;
      rsp_found_in = rsp_found_ff;
      rsp_start_in = rsp_start_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rd_req       = '0;
      wr_req       = '0;
      wr_data      = rd_data;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               elem_in      = req_ch.element_index;
               kind_in      = req_ch.element_kind;
               char_in      = req_ch.character;
               last_in      = req_ch.last_char;
               res_found_in = 1'b0;
               res_start_in = '0;
               res_done_in  = 1'b0;
               state_in     = ST_RESP;
               case (req_ch.action)
                  cpm_pkg::ACT_DEFINE: begin
                     // Unknown kinds and out-of-range elements leave the table alone.
                     if (req_elem_ok && (req_ch.element_kind <= cpm_pkg::KIND_NEG_SET)) begin
                        rd_req.en = 1'b1;
                        rd_req.addr = '0;
                        sweep_in  = '0;
                        state_in  = ST_SWEEP;
                     end
                  end
                  cpm_pkg::ACT_ADD_MEMBER: begin
                     if (req_elem_ok) begin
                        rd_req.en   = 1'b1;
                        rd_req.addr = req_ch.character;
                        state_in    = ST_SET;
                     end
                  end
                  cpm_pkg::ACT_SOURCE: begin
                     rd_req.en   = 1'b1;
                     rd_req.addr = req_ch.character;
                     state_in    = ST_MATCH;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         ST_SWEEP: begin
            // Entry sweep_ff arrives now; the next entry is read in the same cycle.
            wr_req.en   = 1'b1;
            wr_req.addr = sweep_ff;
            wr_data     = element_accepts(kind_ff, sweep_ff, char_ff) ? (rd_data | elem_bit)
                                                                      : (rd_data & ~elem_bit);
            if (sweep_ff == LAST_CHAR_CODE) begin
               state_in = ST_RESP;
            end else begin
               rd_req.en   = 1'b1;
               rd_req.addr = sweep_ff + 1'b1;
               sweep_in    = sweep_ff + 1'b1;
            end
         end

         ST_SET: begin
            // A negated set loses the member; every other kind gains it.
            wr_req.en   = 1'b1;
            wr_req.addr = char_ff;
            wr_data     = (kind_ff == cpm_pkg::KIND_NEG_SET) ? (rd_data & ~elem_bit)
                                                             : (rd_data | elem_bit);
            state_in    = ST_RESP;
         end

         ST_MATCH: begin
            if (!found_ff) begin
               pm_in = next_pm;
               if (next_pm[top_idx]) begin
                  res_found_in = 1'b1;
                  res_start_in = start_sat;
                  res_done_in  = 1'b1;
                  found_in     = 1'b1;
               end else if (last_ff) begin
                  res_done_in = 1'b1;
               end
               if (pos_ff < POS_MAX) begin
                  pos_in = pos_ff + 1'b1;
               end
            end
            // The last character of a search always starts the next one afresh.
            if (last_ff) begin
               pm_in    = '0;
               pos_in   = '0;
               found_in = 1'b0;
            end
            state_in = ST_RESP;
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_start_in = res_start_ff;
               rsp_done_in  = res_done_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sweep_ff     <= '0;
         pm_ff        <= '0;
         pos_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         pm_ff        <= pm_in;
         pos_ff       <= pos_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      elem_ff      <= elem_in;
      kind_ff      <= kind_in;
      char_ff      <= char_in;
      last_ff      <= last_in;
      res_found_ff <= res_found_in;
      res_start_ff <= res_start_in;
      res_done_ff  <= res_done_in;
      rsp_found_ff <= rsp_found_in;
      rsp_start_ff <= rsp_start_in;
      rsp_done_ff  <= rsp_done_in;
   end

endmodule

@@ rtl/cpm_checker.sv @@
// Port-level assertions for the pattern matcher and the bind that attaches them.
module cpm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_match_found,
   input logic [cpm_pkg::START_W-1:0]   rsp_match_start,
   input logic                          rsp_search_done
);

   // A word held back by the sink keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match_start)
                                  && $stable(rsp_match_found) && $stable(rsp_search_done))
      else $error("result word changed while stalled");

   // A match always ends its search.
   a_match_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_match_found |-> rsp_search_done)
      else $error("match reported without search_done");

   // Without a match the start index reads as zero.
   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_match_found |-> rsp_match_start == '0)
      else $error("match_start nonzero without a match");

   // Words are worked on one at a time: right after an acceptance the block is busy.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word accepted back to back");

   // Reset leaves no result word pending.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind character_class_pattern_matcher cpm_checker u_cpm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_match_found (rsp_ch.match_found),
   .rsp_match_start (rsp_ch.match_start),
   .rsp_search_done (rsp_ch.search_done)
);
